// ----- design/fsms_pkg.sv -----
`default_nettype none

package fsms_pkg;

	localparam int CHAR_W        = 8;
	localparam int QLEN_W        = 5;
	localparam int QUERY_SLOTS   = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int SCORE_W       = 16;
	localparam int KIND_W        = 2;
	localparam int PEN_W         = 14;
	localparam int CNT_W         = $clog2(PEN_W);
	localparam int FIFO_DEPTH    = 2;
	localparam int DEF_MAX_QUERY = 24;
	localparam int DEF_MAX_ENTRY = 1024;

	localparam logic [SCORE_W-1:0] SCORE_ONE   = 16'd32768;
	localparam logic [SCORE_W-1:0] SCORE_FLOOR = 16'd328;
	localparam logic [PEN_W-1:0]   GAP_WEIGHT  = 14'd13107;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE      = 2'd0,
		KIND_SUBSTRING = 2'd1,
		KIND_FUZZY     = 2'd2,
		KIND_EMPTY     = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUERY_LENGTH = 2'd0,
		REG_CHARS_LOW    = 2'd1,
		REG_CHARS_MID    = 2'd2,
		REG_CHARS_HIGH   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		kind_t kind;
		logic  sat;
	} job_ctl_t;

endpackage

`default_nettype wire

// ----- design/fsms_in_if.sv -----
`default_nettype none

interface fsms_in_if;
	logic                         valid;
	logic                         ready;
	logic [fsms_pkg::CHAR_W-1:0]  entry_char;
	logic                         char_present;
	logic                         end_of_entry;

	modport source (output valid, entry_char, char_present, end_of_entry, input ready);
	modport sink (input valid, entry_char, char_present, end_of_entry, output ready);
endinterface

`default_nettype wire

// ----- design/fsms_out_if.sv -----
`default_nettype none

interface fsms_out_if;
	logic                          valid;
	logic                          ready;
	logic [fsms_pkg::SCORE_W-1:0]  match_score;
	logic [fsms_pkg::KIND_W-1:0]   match_kind;
	logic                          length_overflow;

	modport source (output valid, match_score, match_kind, length_overflow, input ready);
	modport sink (input valid, match_score, match_kind, length_overflow, output ready);
endinterface

`default_nettype wire

// ----- design/fsms_cfg_if.sv -----
`default_nettype none

interface fsms_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fsms_pkg::CFG_IDX_W-1:0]  index;
	logic [fsms_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/fsms_fifo.sv -----
`default_nettype none

module fsms_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/fsms_front.sv -----
`default_nettype none

module fsms_front #(
	parameter int MAX_QUERY = fsms_pkg::DEF_MAX_QUERY,
	parameter int MAX_ENTRY = fsms_pkg::DEF_MAX_ENTRY,
	parameter int LW        = $clog2(MAX_ENTRY + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	fsms_in_if.sink              entry,
	fsms_cfg_if.sink             cfg,
	input  wire logic            job_full,
	output logic                 job_push,
	output fsms_pkg::job_ctl_t   job_ctl,
	output logic [LW-1:0]        job_gaps,
	output logic [LW-1:0]        job_len
);
	import fsms_pkg::*;

	logic [QLEN_W-1:0]                 qlen_cfg_q;
	logic [QUERY_SLOTS*CHAR_W-1:0]     qchars_q;

	logic [MAX_QUERY-1:0] pv_q, pv_n;
	logic                 sub_q, sub_n;
	logic [QLEN_W-1:0]    qpos_q, qpos_n;
	logic [LW-1:0]        first_q, first_n;
	logic [LW-1:0]        last_q, last_n;
	logic [LW-1:0]        len_q, len_n;
	logic                 fhs_q, fhs_n;
	logic                 sat_q, sat_n;

	logic [CHAR_W-1:0]    c;
	logic [QLEN_W-1:0]    qlen;
	logic [MAX_QUERY-1:0] mask;
	logic [MAX_QUERY-1:0] top_sel;
	logic [CHAR_W-1:0]    qpos_byte;
	logic                 accept;
	logic                 at_max;
	logic                 consume;
	logic                 walk;
	logic                 end_item;
	logic [LW-1:0]        span;
	logic [LW-1:0]        qlen_w;

	assign entry.ready = !job_full;
	assign cfg.ready   = 1'b1;

	always_comb begin
		c = entry.entry_char;
		if (c >= 8'h41 && c <= 8'h5A) begin
			c = c + 8'h20;
		end
		qlen = (qlen_cfg_q > QLEN_W'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY) : qlen_cfg_q;
		mask      = '0;
		top_sel   = '0;
		qpos_byte = '0;
		for (int k = 0; k < MAX_QUERY; k++) begin
			if (QLEN_W'(k) < qlen && qchars_q[CHAR_W*k +: CHAR_W] == c) begin
				mask[k] = 1'b1;
			end
			if (QLEN_W'(k + 1) == qlen) begin
				top_sel[k] = 1'b1;
			end
			if (QLEN_W'(k) == qpos_q) begin
				qpos_byte = qchars_q[CHAR_W*k +: CHAR_W];
			end
		end

		accept   = entry.valid && entry.ready;
		at_max   = (len_q == LW'(MAX_ENTRY));
		consume  = accept && entry.char_present && !at_max;
		end_item = accept && entry.end_of_entry;

		pv_n  = consume ? (((pv_q << 1) | MAX_QUERY'(1)) & mask) : pv_q;
		sub_n = sub_q || (consume && qlen != '0 && |(pv_n & top_sel));
		walk  = consume && (qpos_q < qlen) && (qpos_byte == c);
		fhs_n   = fhs_q || walk;
		first_n = (walk && !fhs_q) ? len_q : first_q;
		last_n  = walk ? len_q : last_q;
		qpos_n  = walk ? qpos_q + QLEN_W'(1) : qpos_q;
		len_n   = consume ? len_q + LW'(1) : len_q;
		sat_n   = sat_q || (accept && entry.char_present && at_max);

		qlen_w   = LW'(qlen);
		span     = last_n - first_n + LW'(1);
		job_gaps = (span > qlen_w) ? span - qlen_w : '0;
		job_len  = len_n;
		job_push = end_item;
		job_ctl.sat = sat_n;
		if (qlen == '0) begin
			job_ctl.kind = KIND_EMPTY;
		end else if (len_n == '0) begin
			job_ctl.kind = KIND_NONE;
		end else if (sub_n) begin
			job_ctl.kind = KIND_SUBSTRING;
		end else if (qpos_n >= qlen && fhs_n) begin
			job_ctl.kind = KIND_FUZZY;
		end else begin
			job_ctl.kind = KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_cfg_q <= '0;
			qchars_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_QUERY_LENGTH: qlen_cfg_q <= cfg.data[QLEN_W-1:0];
				REG_CHARS_LOW:    qchars_q[0*CFG_DATA_W +: CFG_DATA_W] <= cfg.data;
				REG_CHARS_MID:    qchars_q[1*CFG_DATA_W +: CFG_DATA_W] <= cfg.data;
				REG_CHARS_HIGH:   qchars_q[2*CFG_DATA_W +: CFG_DATA_W] <= cfg.data;
				default:          qlen_cfg_q <= qlen_cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= '0;
			sub_q   <= 1'b0;
			qpos_q  <= '0;
			first_q <= '0;
			last_q  <= '0;
			len_q   <= '0;
			fhs_q   <= 1'b0;
			sat_q   <= 1'b0;
		end else if (end_item) begin
			pv_q    <= '0;
			sub_q   <= 1'b0;
			qpos_q  <= '0;
			first_q <= '0;
			last_q  <= '0;
			len_q   <= '0;
			fhs_q   <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			pv_q    <= pv_n;
			sub_q   <= sub_n;
			qpos_q  <= qpos_n;
			first_q <= first_n;
			last_q  <= last_n;
			len_q   <= len_n;
			fhs_q   <= fhs_n;
			sat_q   <= sat_n;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_ENTRY))
		else $error("entry length beyond maximum");

	a_qpos_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(qpos_q != '0) |-> (fhs_q && last_q >= first_q && qpos_q <= QLEN_W'(MAX_QUERY)))
		else $error("walk position without recorded hit");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

endmodule

`default_nettype wire

// ----- design/fsms_back.sv -----
`default_nettype none

module fsms_back #(
	parameter int LW = 11
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                job_valid,
	input  wire fsms_pkg::job_ctl_t  job_ctl,
	input  wire logic [LW-1:0]       job_gaps,
	input  wire logic [LW-1:0]       job_len,
	output logic                     job_pop,
	fsms_out_if.source               result
);
	import fsms_pkg::*;

	localparam int NW = LW + PEN_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t             state_q;
	kind_t              kind_q;
	logic               sat_q;
	logic [NW-1:0]      rem_q;
	logic [NW-1:0]      div_q;
	logic [PEN_W-1:0]   pen_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [SCORE_W-1:0] score_out_q;
	kind_t              kind_out_q;
	logic               ovf_out_q;

	logic               ge;
	logic [SCORE_W-1:0] raw_score;
	logic [SCORE_W-1:0] fin_score;
	logic               out_free;

	assign job_pop  = (state_q == ST_IDLE) && job_valid;
	assign ge       = (rem_q >= div_q);
	assign out_free = !out_valid_q || result.ready;

	assign result.valid           = out_valid_q;
	assign result.match_score     = score_out_q;
	assign result.match_kind      = kind_out_q;
	assign result.length_overflow = ovf_out_q;

	always_comb begin
		raw_score = SCORE_ONE - SCORE_W'(pen_q);
		case (kind_q)
			KIND_EMPTY:     fin_score = SCORE_ONE;
			KIND_SUBSTRING: fin_score = SCORE_ONE;
			KIND_FUZZY:     fin_score = (raw_score < SCORE_FLOOR) ? SCORE_FLOOR : raw_score;
			default:        fin_score = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_NONE;
			sat_q       <= 1'b0;
			rem_q       <= '0;
			div_q       <= '0;
			pen_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			score_out_q <= '0;
			kind_out_q  <= KIND_NONE;
			ovf_out_q   <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						kind_q  <= job_ctl.kind;
						sat_q   <= job_ctl.sat;
						rem_q   <= NW'(job_gaps) * NW'(GAP_WEIGHT);
						div_q   <= NW'(job_len) << (PEN_W - 1);
						pen_q   <= '0;
						cnt_q   <= '0;
						state_q <= (job_ctl.kind == KIND_FUZZY) ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (ge) begin
						rem_q <= rem_q - div_q;
					end
					pen_q <= {pen_q[PEN_W-2:0], ge};
					div_q <= div_q >> 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PEN_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						score_out_q <= fin_score;
						kind_out_q  <= kind_q;
						ovf_out_q   <= sat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CNT_W'(PEN_W)))
		else $error("divide step count overrun");

	a_fuzzy_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_out_q == KIND_FUZZY) |->
			(score_out_q >= SCORE_FLOOR && score_out_q <= SCORE_ONE))
		else $error("fuzzy score out of range");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished score not presented");

endmodule

`default_nettype wire

// ----- design/fuzzy_subsequence_match_scorer_top.sv -----
// Fuzzy subsequence scorer: rates one entry string against a stored query.
// Channels: entry (one byte per request: entry_char, char_present,
// end_of_entry), result (match_score Q1.15, match_kind, length_overflow) and
// cfg (index/data writes of query_length and the three packed query words).
// The front end takes one character per cycle while the queue has room,
// updating a shift-and prefix vector and a greedy subsequence walk; the
// request with end_of_entry set pushes a scoring job into a two-entry queue
// and clears the entry state. The back end pops one job at a time.
// Empty-query, no-match and substring jobs go from the pop to the finish
// state, which loads the output register once it is free; fuzzy jobs first
// run a 14-step restoring divider (one quotient bit per cycle). The divider
// sets the per-entry rate of the back end, and entry.ready drops only while
// the queue is full.
// The result is held in an output register until result.ready; while it
// waits the back end keeps its finished job and the front keeps streaming
// until the queue fills. Reset clears the query registers to zero (empty
// query), the entry state, the queue and the output register.
`default_nettype none

module fuzzy_subsequence_match_scorer_top #(
	parameter int MAX_QUERY = fsms_pkg::DEF_MAX_QUERY,
	parameter int MAX_ENTRY = fsms_pkg::DEF_MAX_ENTRY
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fsms_in_if.sink     entry,
	fsms_cfg_if.sink    cfg,
	fsms_out_if.source  result
);
	import fsms_pkg::*;

	localparam int LW    = $clog2(MAX_ENTRY + 1);
	localparam int CTL_W = $bits(job_ctl_t);
	localparam int JW    = CTL_W + 2 * LW;

	logic          push;
	job_ctl_t      push_ctl;
	logic [LW-1:0] push_gaps;
	logic [LW-1:0] push_len;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	logic [JW-1:0] q_data;
	job_ctl_t      pop_ctl;
	logic [LW-1:0] pop_gaps;
	logic [LW-1:0] pop_len;

	fsms_front #(
		.MAX_QUERY (MAX_QUERY),
		.MAX_ENTRY (MAX_ENTRY),
		.LW        (LW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry    (entry),
		.cfg      (cfg),
		.job_full (q_full),
		.job_push (push),
		.job_ctl  (push_ctl),
		.job_gaps (push_gaps),
		.job_len  (push_len)
	);

	fsms_fifo #(
		.WIDTH (JW),
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data ({push_ctl, push_gaps, push_len}),
		.full    (q_full),
		.rd_en   (pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	assign pop_ctl  = job_ctl_t'(q_data[JW-1 -: CTL_W]);
	assign pop_gaps = q_data[2*LW-1 -: LW];
	assign pop_len  = q_data[LW-1:0];

	fsms_back #(
		.LW (LW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job_ctl   (pop_ctl),
		.job_gaps  (pop_gaps),
		.job_len   (pop_len),
		.job_pop   (pop),
		.result    (result)
	);

endmodule

`default_nettype wire
